// ===== rtl/tfe_pkg.sv =====
// Shared widths, register indexes, pixel modes and color helpers for the
// tile to framebuffer expander. No dependencies.
`default_nettype none

package tfe_pkg;

   localparam int ADDRESS_BITS_DEF = 22;
   localparam int WORD_ADDR_W      = 22;
   localparam int PIXEL_W          = 32;
   localparam int COLOR_W          = 24;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 24;
   localparam int REQ_TDATA_W      = 24;
   localparam int RSP_TDATA_W      = 56;
   localparam int POS_W            = 13;
   localparam int PROD_W           = 29;
   localparam int SUM_W            = 30;

   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_COLOR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_OFFSET     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_OFFSET     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_BYTES   = 3'd4;

   localparam logic [1:0] MODE_RGB565 = 2'd0;
   localparam logic [1:0] MODE_RGB32  = 2'd1;

   localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;

   function automatic logic [PIXEL_W-1:0] color_565(input logic [COLOR_W-1:0] c);
      return {16'd0, c[23:19], c[15:10], c[7:3]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tile_to_framebuffer_expander.sv =====
// In a supported pixel mode the first framebuffer word passes the multiply state, read stage
// and output register after the eighth column word of a tile is accepted; the 64 words of
// a tile then leave one per cycle while the output does not stall. Per tile the block takes
// 8 column words, a multiply step, 64 pixel reads through the single read port of the column
// memory and a drain of the read stage. Reset: synchronous, active high; configuration
// returns to its reset values and the column count and tile index clear. Depends on tfe_pkg.
`default_nettype none

module tile_to_framebuffer_expander #(
   parameter int ADDRESS_BITS = tfe_pkg::ADDRESS_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // tile_col [7:0], tile_row [15:8], column_bits [23:16]
   input  wire  [tfe_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // run_end
   input  wire                                  req_tlast,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // word_address [21:0], pixel_value [53:22], zero [55:54]
   output logic [tfe_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // tile_done
   output logic                                 rsp_tlast,
   input  wire                                  csr_we,
   input  wire  [tfe_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [tfe_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int ACC_W = (ADDRESS_BITS > tfe_pkg::SUM_W) ? ADDRESS_BITS : tfe_pkg::SUM_W;

   localparam logic [1:0] ST_COLLECT = 2'd0;
   localparam logic [1:0] ST_MUL     = 2'd1;
   localparam logic [1:0] ST_EMIT    = 2'd2;

   logic [1:0]                     pixel_mode_ff;
   logic [tfe_pkg::COLOR_W-1:0]    active_color_ff;
   logic [11:0]                    x_offset_ff;
   logic [11:0]                    y_offset_ff;
   logic [15:0]                    line_bytes_ff;

   logic [1:0]                     state_ff, state_in;
   logic [2:0]                     count_ff, count_in;
   logic [7:0]                     tile_index_ff, tile_index_in;
   logic [5:0]                     pix_ff;

   logic [7:0]                     column_mem [8];
   logic [7:0]                     rd_data_ff;

   logic [tfe_pkg::POS_W-1:0]      xbase_ff;
   logic [tfe_pkg::POS_W-1:0]      ybase_ff;
   logic [tfe_pkg::PROD_W-1:0]     row_prod_ff;
   logic                           half_ff;
   logic [tfe_pkg::PIXEL_W-1:0]    on_ff;

   logic                           a_valid_ff;
   logic [ADDRESS_BITS-1:0]        a_addr_ff;
   logic [2:0]                     a_y_ff;
   logic                           a_last_ff;

   logic                           rsp_valid_ff;
   logic [tfe_pkg::WORD_ADDR_W-1:0] rsp_addr_ff;
   logic [tfe_pkg::PIXEL_W-1:0]    rsp_pixel_ff;
   logic                           rsp_last_ff;

   logic [7:0]                     in_col;
   logic [7:0]                     in_row;
   logic [7:0]                     in_bits;
   logic                           req_accept;
   logic                           mode_ok;
   logic [8:0]                     tile_pos;
   logic [tfe_pkg::POS_W-1:0]      xbase_calc;
   logic [tfe_pkg::POS_W-1:0]      ybase_calc;
   logic                           out_free;
   logic                           rd_en;
   logic [tfe_pkg::PROD_W-1:0]     line_part;
   logic [ACC_W-1:0]               addr_sum;
   logic [ACC_W-1:0]               a_addr_ext;

   assign in_col     = req_tdata[7:0];
   assign in_row     = req_tdata[15:8];
   assign in_bits    = req_tdata[23:16];
   // The pixel in the read stage still needs the color of its own tile.
   assign req_tready = (state_ff == ST_COLLECT) && !a_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign mode_ok    = (pixel_mode_ff == tfe_pkg::MODE_RGB565) ||
                       (pixel_mode_ff == tfe_pkg::MODE_RGB32);

   assign tile_pos   = {1'b0, in_col} + {1'b0, tile_index_ff};
   assign xbase_calc = {1'b0, tile_pos, 3'b000} + {1'b0, x_offset_ff};
   assign ybase_calc = {2'b00, in_row, 3'b000} + {1'b0, y_offset_ff};

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rd_en      = (state_ff == ST_EMIT) && (!a_valid_ff || out_free);
   assign line_part  = half_ff ? (row_prod_ff >> 1) : (row_prod_ff >> 2);
   assign addr_sum   = ACC_W'(xbase_ff) + ACC_W'(pix_ff[2:0]) + ACC_W'(line_part);
   assign a_addr_ext = ACC_W'(a_addr_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      tile_index_in = tile_index_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_accept) begin
               if (count_ff != 3'd7) begin
                  if (req_tlast) begin
                     count_in      = 3'd0;
                     tile_index_in = 8'd0;
                  end else begin
                     count_in = count_ff + 3'd1;
                  end
               end else begin
                  count_in      = 3'd0;
                  tile_index_in = req_tlast ? 8'd0 : tile_index_ff + 8'd1;
                  if (mode_ok) begin
                     state_in = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rd_en && (&pix_ff)) begin
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff   <= tfe_pkg::MODE_RGB32;
         active_color_ff <= tfe_pkg::WHITE;
         x_offset_ff     <= 12'd0;
         y_offset_ff     <= 12'd0;
         line_bytes_ff   <= 16'd0;
      end else if (csr_we) begin
         case (csr_index)
            tfe_pkg::CSR_PIXEL_MODE:   pixel_mode_ff   <= csr_wdata[1:0];
            tfe_pkg::CSR_ACTIVE_COLOR: active_color_ff <= csr_wdata[23:0];
            tfe_pkg::CSR_X_OFFSET:     x_offset_ff     <= csr_wdata[11:0];
            tfe_pkg::CSR_Y_OFFSET:     y_offset_ff     <= csr_wdata[11:0];
            tfe_pkg::CSR_LINE_BYTES:   line_bytes_ff   <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_COLLECT;
         count_ff      <= 3'd0;
         tile_index_ff <= 8'd0;
         pix_ff        <= 6'd0;
         a_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         tile_index_ff <= tile_index_in;
         if (rd_en) begin
            pix_ff <= pix_ff + 6'd1;
         end
         if (rd_en) begin
            a_valid_ff <= 1'b1;
         end else if (out_free) begin
            a_valid_ff <= 1'b0;
         end
         if (a_valid_ff && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         column_mem[count_ff] <= in_bits;
      end
      if (rd_en) begin
         rd_data_ff <= column_mem[pix_ff[2:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (count_ff == 3'd7)) begin
         xbase_ff <= xbase_calc;
         ybase_ff <= ybase_calc;
         half_ff  <= (pixel_mode_ff == tfe_pkg::MODE_RGB565);
         on_ff    <= (pixel_mode_ff == tfe_pkg::MODE_RGB565) ?
                     tfe_pkg::color_565(active_color_ff) :
                     {8'd0, active_color_ff};
      end
      if (state_ff == ST_MUL) begin
         row_prod_ff <= tfe_pkg::PROD_W'(ybase_ff) * tfe_pkg::PROD_W'(line_bytes_ff);
      end else if (rd_en && (pix_ff[2:0] == 3'd7)) begin
         row_prod_ff <= row_prod_ff + tfe_pkg::PROD_W'(line_bytes_ff);
      end
      if (rd_en) begin
         a_addr_ff <= addr_sum[ADDRESS_BITS-1:0];
         a_y_ff    <= pix_ff[5:3];
         a_last_ff <= &pix_ff;
      end
      if (a_valid_ff && out_free) begin
         rsp_addr_ff  <= a_addr_ext[tfe_pkg::WORD_ADDR_W-1:0];
         rsp_pixel_ff <= rd_data_ff[a_y_ff] ? on_ff : '0;
         rsp_last_ff  <= a_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_pixel_ff, rsp_addr_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_mul_then_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff == ST_EMIT))
      else $error("Multiply cycle was not followed by emission.");

   a_tile_start_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (count_ff == 3'd0) && (pix_ff == 6'd0))
      else $error("Tile started with a nonzero column or pixel count.");

   a_stalled_read_holds: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !out_free) |=> $stable(rd_data_ff) && $stable(a_addr_ff))
      else $error("Held pixel read was overwritten while the output stalled.");

   a_done_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rd_en && (&pix_ff)) |=> (state_ff == ST_COLLECT))
      else $error("Emission continued past the last pixel of a tile.");

endmodule

`default_nettype wire

// ===== sim/tb_tile_to_framebuffer_expander.sv =====
// Self-checking testbench for tile_to_framebuffer_expander: drives column words,
// predicts every framebuffer write and checks the result stream in order.
// Depends on tfe_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_tile_to_framebuffer_expander;

   localparam logic [1:0] MODE_UNSUPPORTED    = 2'd2;
   localparam logic [1:0] MODE_UNSUPPORTED_HI = 2'd3;
   localparam int SETTLE_CYCLES = 120;

   typedef struct packed {
      logic [tfe_pkg::WORD_ADDR_W-1:0] addr;
      logic [tfe_pkg::PIXEL_W-1:0]     pixel;
      logic                            done;
   } fb_write_type;

   class fb_write_scoreboard_type;
      logic [1:0]                  mode = tfe_pkg::MODE_RGB32;
      logic [tfe_pkg::COLOR_W-1:0] color = tfe_pkg::WHITE;
      logic [11:0]                 xoff = '0;
      logic [11:0]                 yoff = '0;
      logic [15:0]                 line_bytes = '0;
      logic [7:0]                  columns [8];
      logic [2:0]                  col_count = '0;
      logic [7:0]                  tile_idx = '0;
      fb_write_type                pending_writes [$];
      int                          errors = 0;

      function void set_reg(input logic [tfe_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [23:0] value);
         case (idx)
            tfe_pkg::CSR_PIXEL_MODE:   mode = value[1:0];
            tfe_pkg::CSR_ACTIVE_COLOR: color = value;
            tfe_pkg::CSR_X_OFFSET:     xoff = value[11:0];
            tfe_pkg::CSR_Y_OFFSET:     yoff = value[11:0];
            tfe_pkg::CSR_LINE_BYTES:   line_bytes = value[15:0];
            default: ;
         endcase
      endfunction

      function void note_column(input logic [7:0] col, input logic [7:0] row,
                                input logic [7:0] bits, input logic last);
         int unsigned       shift;
         logic [31:0]       lit_pixel;
         longint unsigned   xpix;
         longint unsigned   ypix;
         longint unsigned   line_part;
         longint unsigned   addr;
         fb_write_type      w;
         columns[col_count] = bits;
         if (col_count != 3'd7) begin
            if (last) begin
               col_count = '0;
               tile_idx = '0;
            end else begin
               col_count = col_count + 3'd1;
            end
            return;
         end
         col_count = '0;
         if (mode == tfe_pkg::MODE_RGB565) begin
            shift = 1;
            lit_pixel = ((32'(color[23:16]) >> 3) << 11) | ((32'(color[15:8]) >> 2) << 5)
                        | (32'(color[7:0]) >> 3);
         end else if (mode == tfe_pkg::MODE_RGB32) begin
            shift = 2;
            lit_pixel = 32'(color);
         end else begin
            tile_idx = last ? 8'd0 : tile_idx + 8'd1;
            return;
         end
         for (int y = 0; y < 8; y++) begin
            ypix = 64'(row) * 8 + 64'(y) + 64'(yoff);
            line_part = (ypix * 64'(line_bytes)) >> shift;
            for (int x = 0; x < 8; x++) begin
               xpix = (64'(col) + 64'(tile_idx)) * 8 + 64'(x) + 64'(xoff);
               addr = xpix + line_part;
               w.addr = addr[tfe_pkg::WORD_ADDR_W-1:0];
               w.pixel = columns[x][y] ? lit_pixel : 32'd0;
               w.done = (y == 7 && x == 7);
               pending_writes.push_back(w);
            end
         end
         tile_idx = last ? 8'd0 : tile_idx + 8'd1;
      endfunction

      task flag_mismatch(input string what, input longint unsigned got,
                         input longint unsigned want);
         $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
         errors++;
      endtask

      task check_write(input logic [tfe_pkg::WORD_ADDR_W-1:0] addr,
                       input logic [tfe_pkg::PIXEL_W-1:0] pixel, input logic done);
         fb_write_type w;
         if (pending_writes.size() == 0) begin
            flag_mismatch("unexpected word", addr, 0);
            return;
         end
         w = pending_writes.pop_front();
         if (addr !== w.addr) flag_mismatch("word_address", addr, w.addr);
         if (pixel !== w.pixel) flag_mismatch("pixel_value", pixel, w.pixel);
         if (done !== w.done) flag_mismatch("tile_done", done, w.done);
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [tfe_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                            req_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [tfe_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_we;
   logic [tfe_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tfe_pkg::CSR_DATA_W-1:0]  csr_wdata;

   int unsigned send_idle_pct = 21;
   int unsigned recv_idle_pct = 81;
   fb_write_scoreboard_type sb = new();

   tile_to_framebuffer_expander uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_write(rsp_tdata[21:0], rsp_tdata[53:22], rsp_tlast);
      end
   end

   task automatic send_column(input logic [7:0] col, input logic [7:0] row,
                              input logic [7:0] bits, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {bits, row, col};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_column(col, row, bits, last);
      @(negedge clock);
   endtask

   task automatic send_tiles(input int n_tiles, input int unsigned noise_pct,
                             input logic end_run, inout int sent);
      logic last;
      for (int t = 0; t < n_tiles; t++) begin
         for (int k = 0; k < 8; k++) begin
            last = (end_run && t == n_tiles - 1 && k == 7) || ($urandom_range(99) < noise_pct);
            send_column(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), last);
            sent++;
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_writes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [tfe_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [23:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic write_config(input logic [1:0] mode, input logic [23:0] color,
                               input logic [11:0] xo, input logic [11:0] yo,
                               input logic [15:0] lb);
      write_reg(tfe_pkg::CSR_PIXEL_MODE, 24'(mode));
      write_reg(tfe_pkg::CSR_ACTIVE_COLOR, color);
      write_reg(tfe_pkg::CSR_X_OFFSET, 24'(xo));
      write_reg(tfe_pkg::CSR_Y_OFFSET, 24'(yo));
      write_reg(tfe_pkg::CSR_LINE_BYTES, 24'(lb));
      csr_we <= 1'b0;
   endtask

   function automatic logic [23:0] pick_value(input int unsigned hi);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 20) return 24'd0;
      if (r < 40) return 24'(hi);
      return 24'($urandom_range(hi));
   endfunction

   task automatic random_config();
      logic [1:0] mode;
      int unsigned r;
      r = $urandom_range(99);
      mode = (r < 40) ? tfe_pkg::MODE_RGB565 : (r < 80) ? tfe_pkg::MODE_RGB32 :
             (r < 90) ? MODE_UNSUPPORTED : MODE_UNSUPPORTED_HI;
      write_config(mode, pick_value(24'hFFFFFF), pick_value(4095), pick_value(4095),
                   pick_value(65535));
   endtask

   initial begin
      #20_000_000;
      $display("tb_tile_to_framebuffer_expander failed");
      $finish;
   end

   initial begin
      logic [7:0] pattern [8];
      int sent;
      pattern = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0};
      sent = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      rsp_tready <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A tile under the reset configuration that ends its run on the eighth word.
      for (int k = 0; k < 8; k++) send_column(8'd0, 8'd0, pattern[k], k == 7);
      // A run ended after three words drops the partial tile.
      for (int k = 0; k < 3; k++) send_column(8'd3, 8'd4, pattern[k + 1], k == 2);
      drain();
      // Largest position, offsets and line length overflow the word address.
      write_config(tfe_pkg::MODE_RGB565, 24'h84_21_08, 12'hFFF, 12'hFFF, 16'hFFFF);
      for (int k = 0; k < 8; k++) send_column(8'hFF, 8'hFF, pattern[7 - k], 1'b0);
      drain();

      // Unsupported modes write nothing but still advance the tile index.
      send_idle_pct = 81;
      recv_idle_pct = 21;
      write_reg(tfe_pkg::CSR_PIXEL_MODE, 24'(MODE_UNSUPPORTED));
      csr_we <= 1'b0;
      send_tiles(1, 0, 1'b0, sent);
      drain();
      write_reg(tfe_pkg::CSR_PIXEL_MODE, 24'(MODE_UNSUPPORTED_HI));
      csr_we <= 1'b0;
      send_tiles(1, 0, 1'b0, sent);
      drain();
      write_config(tfe_pkg::MODE_RGB32, 24'h123456, 12'd17, 12'd5, 16'd640);
      send_tiles(2, 0, 1'b1, sent);
      drain();

      for (int round = 0; round < 3; round++) begin
         send_idle_pct = (round == 0) ? 21 : (round == 1) ? 81 : 0;
         recv_idle_pct = (round == 0) ? 81 : (round == 1) ? 21 : 0;
         sent = 0;
         while (sent < 16) begin
            drain();
            random_config();
            repeat ($urandom_range(1, 2)) begin
               send_tiles($urandom_range(1, 3), 4, $urandom_range(3) != 0, sent);
               if ($urandom_range(99) < 30) drain();
            end
         end
      end
      drain();

      if (sb.errors == 0 && sb.pending_writes.size() == 0) begin
         $display("tb_tile_to_framebuffer_expander passed");
      end else begin
         $display("tb_tile_to_framebuffer_expander failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tfe_pkg.sv
rtl/tile_to_framebuffer_expander.sv
sim/tb_tile_to_framebuffer_expander.sv
